// ===== hw/rtl/gbts_pkg.sv =====
// Shared types and codes for the gap buffer text store.
package gbts_pkg;

  localparam int FieldW = 13;
  localparam int ArgW   = 14;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_DEL_BEFORE = 3'd1,
    OP_DEL_AFTER  = 3'd2,
    OP_SET_CURSOR = 3'd3,
    OP_MOVE       = 3'd4,
    OP_READ       = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_INSERT,
    K_DEL_BEFORE,
    K_DEL_AFTER,
    K_PLACE_ABS,
    K_PLACE_REL,
    K_READ,
    K_CLEAR,
    K_NOP
  } kind_t;

  // One classified command: byte for inserts, one operand for the rest.
  typedef struct packed {
    kind_t           kind;
    logic [7:0]      ch;
    logic [ArgW-1:0] arg;
  } cmd_t;

endpackage

// ===== hw/rtl/gap_buffer_text_store.sv =====
// Top level of the gap buffer text store: front end, command queue and executor.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | op, char_value, count, position, delta
//  out     | output    | out_valid / out_stall| read_byte, text_length, cursor_pos, status
//
//  Insert, delete, read, clear and unused ops go from issue to S_FIN, which
//  loads the result register; set and move pass through S_MV_RD and S_MV_WR
//  once for each byte the cursor travels before S_FIN: each byte crossing the
//  gap is a registered memory read followed by a write.
//  Synchronous active-high reset returns the gap to empty; the text memory is
//  not cleared.
//  A two-word queue sits between the front end and the executor, so words are
//  taken while a result waits on out_stall; in_stall rises only when it fills.
module gap_buffer_text_store #(
  parameter int CAPACITY = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  op,
  input  logic [7:0]                  char_value,
  input  logic [gbts_pkg::FieldW-1:0] count,
  input  logic [gbts_pkg::FieldW-1:0] position,
  input  logic signed [gbts_pkg::ArgW-1:0] delta,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  read_byte,
  output logic [gbts_pkg::FieldW-1:0] text_length,
  output logic [gbts_pkg::FieldW-1:0] cursor_pos,
  output logic                        status
);

  // Classified command from the front end into the queue.
  logic           push_valid;
  logic           push_stall;
  gbts_pkg::cmd_t push_cmd;

  // Queue head toward the executor.
  logic           q_valid;
  gbts_pkg::cmd_t q_cmd;
  logic           q_pop;

  // Decode op and pack the one operand each op needs.
  gbts_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_value (char_value),
    .count      (count),
    .position   (position),
    .delta      (delta),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd)
  );

  // Hold classified commands while the executor is busy moving the gap.
  gbts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop        (q_pop)
  );

  // Carry out each command against the gap pointers and text memory.
  gbts_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_cmd),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .text_length (text_length),
    .cursor_pos  (cursor_pos),
    .status      (status)
  );

endmodule

// ===== hw/rtl/gbts_front.sv =====
// Front end: take one word, classify the op and pack its operand.
module gbts_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    op,
  input  logic [7:0]                    char_value,
  input  logic [gbts_pkg::FieldW-1:0]   count,
  input  logic [gbts_pkg::FieldW-1:0]   position,
  input  logic signed [gbts_pkg::ArgW-1:0] delta,
  output logic                          push_valid,
  input  logic                          push_stall,
  output gbts_pkg::cmd_t                push_cmd
);

  assign in_stall   = push_stall;
  assign push_valid = in_valid;

  always_comb begin
    push_cmd.ch   = char_value;
    push_cmd.arg  = '0;
    push_cmd.kind = gbts_pkg::K_NOP;
    case (op)
      gbts_pkg::OP_INSERT: begin
        push_cmd.kind = gbts_pkg::K_INSERT;
      end
      gbts_pkg::OP_DEL_BEFORE: begin
        push_cmd.kind = gbts_pkg::K_DEL_BEFORE;
        push_cmd.arg  = {1'b0, count};
      end
      gbts_pkg::OP_DEL_AFTER: begin
        push_cmd.kind = gbts_pkg::K_DEL_AFTER;
        push_cmd.arg  = {1'b0, count};
      end
      gbts_pkg::OP_SET_CURSOR: begin
        push_cmd.kind = gbts_pkg::K_PLACE_ABS;
        push_cmd.arg  = {1'b0, position};
      end
      gbts_pkg::OP_MOVE: begin
        push_cmd.kind = gbts_pkg::K_PLACE_REL;
        push_cmd.arg  = delta;
      end
      gbts_pkg::OP_READ: begin
        push_cmd.kind = gbts_pkg::K_READ;
        push_cmd.arg  = {1'b0, position};
      end
      gbts_pkg::OP_CLEAR: begin
        push_cmd.kind = gbts_pkg::K_CLEAR;
      end
      default: begin
        push_cmd.kind = gbts_pkg::K_NOP;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gbts_queue.sv =====
// Two-entry command queue between the front end and the executor.
module gbts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_stall,
  input  gbts_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  output gbts_pkg::cmd_t pop_cmd,
  input  logic           pop
);

  localparam int Depth = 2;

  gbts_pkg::cmd_t slots [Depth];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;

  assign push_stall = (fill == 2'(Depth));
  assign push       = push_valid && !push_stall;
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/gbts_back.sv =====
// Executor: gap pointers, text memory, gap move sequencer and result register.
module gbts_back #(
  parameter int CAPACITY = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  input  gbts_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  read_byte,
  output logic [gbts_pkg::FieldW-1:0] text_length,
  output logic [gbts_pkg::FieldW-1:0] cursor_pos,
  output logic                        status
);

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int WW = ((PW > gbts_pkg::ArgW) ? PW : gbts_pkg::ArgW) + 1;
  localparam logic [WW-1:0] CapW = WW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MV_RD = 4'b0010,
    S_MV_WR = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t         state;
  state_t         state_next;
  logic [PW-1:0]  gap_start;
  logic [PW-1:0]  gap_end;
  logic [PW-1:0]  target;
  logic           mv_left;
  logic           status_r;
  logic           rd_sel;

  logic [7:0]     mem [CAPACITY];
  logic [7:0]     mem_q;
  logic           mem_we;
  logic           mem_re;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_wdata;

  logic [WW-1:0]  gs_w;
  logic [WW-1:0]  ge_w;
  logic [WW-1:0]  len_w;
  logic [WW-1:0]  arg_u;
  logic [WW:0]    arg_sx;
  logic [WW:0]    np_s;
  logic [WW-1:0]  np_c;
  logic [WW-1:0]  t_raw;
  logic [WW-1:0]  t_cl;
  logic [WW-1:0]  d_before;
  logic [WW-1:0]  avail;
  logic [WW-1:0]  d_after;
  logic           rd_ok;
  logic [WW-1:0]  rd_addr_w;
  logic           has_room;
  logic           is_place;
  logic [PW-1:0]  gs_m1;
  logic [PW-1:0]  ge_m1;
  logic [PW-1:0]  gs_step;
  logic           out_free;

  assign gs_w     = WW'(gap_start);
  assign ge_w     = WW'(gap_end);
  assign len_w    = gs_w + CapW - ge_w;
  assign arg_u    = WW'(cmd.arg);
  assign arg_sx   = {{(WW + 1 - gbts_pkg::ArgW){cmd.arg[gbts_pkg::ArgW-1]}}, cmd.arg};
  assign np_s     = {1'b0, gs_w} + arg_sx;
  assign np_c     = np_s[WW] ? '0 : np_s[WW-1:0];
  assign t_raw    = (cmd.kind == gbts_pkg::K_PLACE_REL) ? np_c : arg_u;
  assign t_cl     = (t_raw > len_w) ? len_w : t_raw;
  assign d_before = (arg_u > gs_w) ? gs_w : arg_u;
  assign avail    = CapW - ge_w;
  assign d_after  = (arg_u > avail) ? avail : arg_u;
  assign rd_ok    = (arg_u < len_w);
  assign rd_addr_w = (arg_u < gs_w) ? arg_u : (ge_w + arg_u - gs_w);
  assign has_room = (gap_start < gap_end);
  assign is_place = (cmd.kind == gbts_pkg::K_PLACE_ABS) ||
                    (cmd.kind == gbts_pkg::K_PLACE_REL);
  assign gs_m1    = gap_start - PW'(1);
  assign ge_m1    = gap_end - PW'(1);
  assign gs_step  = mv_left ? gs_m1 : (gap_start + PW'(1));
  assign out_free = !out_valid || !out_stall;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = gap_start[AW-1:0];
    mem_raddr = rd_addr_w[AW-1:0];
    mem_wdata = cmd.ch;
    case (state)
      S_IDLE: begin
        if (cmd_valid && (cmd.kind == gbts_pkg::K_INSERT) && has_room) begin
          mem_we = 1'b1;
        end
        if (cmd_valid && (cmd.kind == gbts_pkg::K_READ) && rd_ok) begin
          mem_re = 1'b1;
        end
      end
      S_MV_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mv_left ? gs_m1[AW-1:0] : gap_end[AW-1:0];
      end
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mv_left ? ge_m1[AW-1:0] : gap_start[AW-1:0];
        mem_wdata = mem_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (is_place && (t_cl != gs_w)) begin
            state_next = S_MV_RD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MV_RD: begin
        state_next = S_MV_WR;
      end
      S_MV_WR: begin
        state_next = (gs_step == target) ? S_FIN : S_MV_RD;
      end
      S_FIN: begin
        state_next = out_free ? S_IDLE : S_FIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_start <= '0;
      gap_end   <= PW'(CAPACITY);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            status_r <= 1'b0;
            rd_sel   <= 1'b0;
            case (cmd.kind)
              gbts_pkg::K_INSERT: begin
                if (has_room) begin
                  gap_start <= gap_start + PW'(1);
                end else begin
                  status_r <= 1'b1;
                end
              end
              gbts_pkg::K_DEL_BEFORE: begin
                gap_start <= PW'(gs_w - d_before);
              end
              gbts_pkg::K_DEL_AFTER: begin
                gap_end <= PW'(ge_w + d_after);
              end
              gbts_pkg::K_PLACE_ABS, gbts_pkg::K_PLACE_REL: begin
                target  <= PW'(t_cl);
                mv_left <= (t_cl < gs_w);
              end
              gbts_pkg::K_READ: begin
                rd_sel <= rd_ok;
              end
              gbts_pkg::K_CLEAR: begin
                gap_start <= '0;
                gap_end   <= PW'(CAPACITY);
              end
              default: begin
                status_r <= 1'b0;
              end
            endcase
          end
        end
        S_MV_WR: begin
          // Shift the gap one byte toward the target.
          gap_start <= gs_step;
          gap_end   <= mv_left ? ge_m1 : (gap_end + PW'(1));
        end
        default: begin
          status_r <= status_r;
        end
      endcase
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      read_byte   <= rd_sel ? mem_q : 8'd0;
      text_length <= len_w[gbts_pkg::FieldW-1:0];
      cursor_pos  <= gs_w[gbts_pkg::FieldW-1:0];
      status      <= status_r;
    end
  end

  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_start <= gap_end)
    else $error("gap start passed gap end");

  a_gap_bound: assert property (@(posedge clk) disable iff (rst)
    gap_end <= PW'(CAPACITY))
    else $error("gap end beyond capacity");

  a_move_keeps_gap: assert property (@(posedge clk) disable iff (rst)
    (state == S_MV_WR) |=> ((gap_end - gap_start) == $past(gap_end - gap_start)))
    else $error("gap size changed during a cursor move");

  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_free) |=> out_valid)
    else $error("finished command produced no result");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state != S_IDLE))
    else $error("accepted command did not start");

endmodule
